[rtl/core/tqme_pkg.sv]
// Shared types, constants and helpers for the touch quadrant mapper.
// No dependencies; every other file imports this package.
package tqme_pkg;

   localparam int COORD_BITS     = 12;
   localparam int SCREEN_BITS    = 12;
   localparam int AXIS_BITS      = COORD_BITS + 1;
   localparam int FLIP_BITS      = COORD_BITS + 3;
   localparam int NUM_BITS       = 2 * COORD_BITS;
   localparam int CSR_DATA_BITS  = 2 * COORD_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int ORIENT_BITS    = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWER_SPAN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER_SPAN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_END  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIENT      = 3'd5;

   localparam logic [CSR_DATA_BITS-1:0] LOWER_SPAN_RESET = 24'h7FF7FF;
   localparam logic [CSR_DATA_BITS-1:0] UPPER_SPAN_RESET = 24'h800800;

   localparam int ORIENT_HFLIP = 0;
   localparam int ORIENT_VFLIP = 1;
   localparam int ORIENT_SWAP  = 2;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PUSH    = 2'd1,
      EV_DRAG    = 2'd2,
      EV_RELEASE = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] origin;
      logic [CSR_DATA_BITS-1:0] lower_span;
      logic [CSR_DATA_BITS-1:0] upper_span;
      logic [CSR_DATA_BITS-1:0] center;
      logic [CSR_DATA_BITS-1:0] screen_end;
      logic [ORIENT_BITS-1:0]   orient;
   } cfg_type;

   function automatic logic [COORD_BITS-1:0] field_of(
      input logic [CSR_DATA_BITS-1:0] r, input logic hi);
      return hi ? r[2*COORD_BITS-1:COORD_BITS] : r[COORD_BITS-1:0];
   endfunction

   function automatic logic [SCREEN_BITS-1:0] clamp_screen(
      input logic signed [FLIP_BITS-1:0] v);
      logic [SCREEN_BITS-1:0] res;
      if (v[FLIP_BITS-1]) begin
         res = '0;
      end else if (v > $signed(FLIP_BITS'((1 << SCREEN_BITS) - 1))) begin
         res = '1;
      end else begin
         res = v[SCREEN_BITS-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [FLIP_BITS-1:0] orient_axis(
      input logic flip, input logic [COORD_BITS-1:0] end_v,
      input logic [AXIS_BITS-1:0] v);
      logic signed [FLIP_BITS-1:0] res;
      if (flip) begin
         res = $signed({3'b000, end_v}) - $signed({2'b00, v});
      end else begin
         res = $signed({2'b00, v});
      end
      return res;
   endfunction

endpackage

[rtl/core/touch_quadrant_map_and_events_top.sv]
// Touch quadrant mapper top level: sequencer, axis datapath and output register.
// Depends on tqme_pkg, tqme_csr and tqme_div.
//
// Use: one raw touch sample is offered on the req_ channel (sample flag, raw x, raw y)
// and exactly one result comes back on the rsp_ channel (event kind, screen x, y).
// A transfer happens on a rising edge with valid high and stall low.
// The csr_ port writes the calibration registers; write only while the block is idle.
// Flow: a present sample maps x, then y, through one shared 24-step serial divider;
// each axis goes through setup (ST_MAP), the divider (ST_DIV) and post (ST_POST),
// and req_stall drops at the edge that loads the result. An axis whose offset is
// not positive or whose span is zero skips the divider. A sample with the flag
// low skips both axes. Throughput: one sample at a time;
// req_stall is high from transfer until the result is loaded into the output register.
// Stall: the result waits in the output register while rsp_stall is high; the
// sequencer holds in its final state until that register is free.
// Reset: synchronous, active high; clears registers to their defaults, touch state and
// last position to zero, and leaves no result pending.
module touch_quadrant_map_and_events_top import tqme_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_sample_valid,
   input  logic [COORD_BITS-1:0]     req_raw_x,
   input  logic [COORD_BITS-1:0]     req_raw_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_event_kind,
   output logic [SCREEN_BITS-1:0]    rsp_screen_x,
   output logic [SCREEN_BITS-1:0]    rsp_screen_y,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MAP  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_POST = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;
   logic      touching_ff, touching_in;
   logic [SCREEN_BITS-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [SCREEN_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic      sample_ff, sample_in;
   logic [COORD_BITS-1:0] raw_x_ff, raw_x_in, raw_y_ff, raw_y_in;
   logic      skip_ff, skip_in, upper_ff, upper_in;
   logic [COORD_BITS-1:0] ctr_ff, ctr_in;
   logic [AXIS_BITS-1:0]  ax_x_ff, ax_x_in, ax_y_ff, ax_y_in;

   logic [COORD_BITS-1:0] raw_sel, org, lo, up, ctr, span, mag;
   logic signed [COORD_BITS:0] diff, above;
   logic      is_upper, nonpos, skip;
   logic [NUM_BITS-1:0]   product, div_q, q_sel;
   logic      div_start, div_done;
   logic [COORD_BITS-1:0] q_clamp;
   logic [AXIS_BITS-1:0]  axis_val;
   logic [SCREEN_BITS-1:0] fx, fy, out_x, out_y;
   logic      slot_free;

   tqme_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tqme_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_q)
   );

   assign raw_sel  = axis_ff ? raw_y_ff : raw_x_ff;
   assign org      = field_of(cfg.origin, axis_ff);
   assign lo       = field_of(cfg.lower_span, axis_ff);
   assign up       = field_of(cfg.upper_span, axis_ff);
   assign ctr      = field_of(cfg.center, axis_ff);
   assign diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, org});
   assign is_upper = diff > $signed({1'b0, lo});
   assign above    = diff - $signed({1'b0, lo});
   assign mag      = is_upper ? above[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
   assign span     = is_upper ? up : lo;
   assign nonpos   = !is_upper && (diff[COORD_BITS] || diff == '0);
   assign skip     = nonpos || span == '0;
   assign product  = NUM_BITS'(mag) * NUM_BITS'(ctr);
   assign div_start = (state_ff == ST_MAP) && !skip;

   assign q_sel    = skip_ff ? '0 : div_q;
   assign q_clamp  = (q_sel > NUM_BITS'(ctr_ff)) ? ctr_ff : q_sel[COORD_BITS-1:0];
   assign axis_val = upper_ff ? ({1'b0, q_clamp} + {1'b0, ctr_ff} + AXIS_BITS'(1))
                              : {1'b0, q_clamp};

   assign fx = clamp_screen(orient_axis(cfg.orient[ORIENT_HFLIP],
                                        field_of(cfg.screen_end, 1'b0), ax_x_ff));
   assign fy = clamp_screen(orient_axis(cfg.orient[ORIENT_VFLIP],
                                        field_of(cfg.screen_end, 1'b1), ax_y_ff));
   assign out_x = cfg.orient[ORIENT_SWAP] ? fy : fx;
   assign out_y = cfg.orient[ORIENT_SWAP] ? fx : fy;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      touching_in  = touching_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      sample_in    = sample_ff;
      raw_x_in     = raw_x_ff;
      raw_y_in     = raw_y_ff;
      skip_in      = skip_ff;
      upper_in     = upper_ff;
      ctr_in       = ctr_ff;
      ax_x_in      = ax_x_ff;
      ax_y_in      = ax_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample_valid;
               raw_x_in  = req_raw_x;
               raw_y_in  = req_raw_y;
               axis_in   = 1'b0;
               state_in  = req_sample_valid ? ST_MAP : ST_DONE;
            end
         end
         ST_MAP: begin
            skip_in  = skip;
            upper_in = is_upper;
            ctr_in   = ctr;
            state_in = skip ? ST_POST : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (axis_ff) begin
               ax_y_in  = axis_val;
               state_in = ST_DONE;
            end else begin
               ax_x_in  = axis_val;
               axis_in  = 1'b1;
               state_in = ST_MAP;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               priority if (sample_ff) begin
                  rsp_kind_in = touching_ff ? EV_DRAG : EV_PUSH;
                  rsp_x_in    = out_x;
                  rsp_y_in    = out_y;
                  last_x_in   = out_x;
                  last_y_in   = out_y;
                  touching_in = 1'b1;
               end else if (touching_ff) begin
                  rsp_kind_in = EV_RELEASE;
                  rsp_x_in    = last_x_ff;
                  rsp_y_in    = last_y_ff;
                  touching_in = 1'b0;
               end else begin
                  rsp_kind_in = EV_NONE;
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         touching_ff  <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         touching_ff  <= touching_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      sample_ff   <= sample_in;
      raw_x_ff    <= raw_x_in;
      raw_y_ff    <= raw_y_in;
      skip_ff     <= skip_in;
      upper_ff    <= upper_in;
      ctr_ff      <= ctr_in;
      ax_x_ff     <= ax_x_in;
      ax_y_ff     <= ax_y_in;
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_screen_x   = rsp_x_ff;
   assign rsp_screen_y   = rsp_y_ff;

endmodule

[rtl/core/tqme_csr.sv]
// Configuration register file of the touch quadrant mapper.
// Depends on tqme_pkg for register indexes, reset values and cfg_type.
module tqme_csr import tqme_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_ORIGIN:     cfg_in.origin     = csr_wdata;
            REG_LOWER_SPAN: cfg_in.lower_span = csr_wdata;
            REG_UPPER_SPAN: cfg_in.upper_span = csr_wdata;
            REG_CENTER:     cfg_in.center     = csr_wdata;
            REG_SCREEN_END: cfg_in.screen_end = csr_wdata;
            REG_ORIENT:     cfg_in.orient     = csr_wdata[ORIENT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin     <= '0;
         cfg_ff.lower_span <= LOWER_SPAN_RESET;
         cfg_ff.upper_span <= UPPER_SPAN_RESET;
         cfg_ff.center     <= '0;
         cfg_ff.screen_end <= '0;
         cfg_ff.orient     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/tqme_div.sv]
// Shared bit-serial restoring divider, one quotient bit per cycle.
// Depends on tqme_pkg for operand widths.
module tqme_div import tqme_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_BITS-1:0]   dividend,
   input  logic [COORD_BITS-1:0] divisor,
   output logic                  done,
   output logic [NUM_BITS-1:0]   quotient
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] div_ff, div_in;
   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS:0]   trial;
   logic                  fits;

   assign shifted = {rem_ff, num_ff[NUM_BITS-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], fits};
         rem_in = fits ? trial[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

[rtl/core/tqme_chk.sv]
// Port-level checker for the touch quadrant mapper, bound to the top level.
// Depends on tqme_pkg for event codes and widths.
module tqme_chk import tqme_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_event_kind,
   input logic [SCREEN_BITS-1:0] rsp_screen_x,
   input logic [SCREEN_BITS-1:0] rsp_screen_y
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_screen_x) && $stable(rsp_screen_y))
      else $error("result changed while stalled");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready straight after a transfer");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_NONE |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("no-event result carries a position");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind touch_quadrant_map_and_events_top tqme_chk u_tqme_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_kind (rsp_event_kind),
   .rsp_screen_x   (rsp_screen_x),
   .rsp_screen_y   (rsp_screen_y)
);

[tb/touch_quadrant_map_and_events_tb.sv]
// Self-checking testbench for touch_quadrant_map_and_events_top: calibrated mapping and events.
// Drives raw samples through a queue-fed driver, predicts each event in place, checks transfers.
// Depends on tqme_pkg and the top level only.
module testbench import tqme_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_SAMPLES = 50;
   localparam int SCREEN_MAX    = (1 << SCREEN_BITS) - 1;
   localparam int SEND_IDLE[4]  = '{0, 75, 0, 30};
   localparam int RECV_STALL[4] = '{0, 0, 75, 30};

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                  present;
      logic [COORD_BITS-1:0] raw_x;
      logic [COORD_BITS-1:0] raw_y;
   } touch_sample_type;

   typedef struct packed {
      event_kind_type         kind;
      logic [SCREEN_BITS-1:0] x;
      logic [SCREEN_BITS-1:0] y;
   } touch_event_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_sample_valid = 1'b0;
   logic [COORD_BITS-1:0]     req_raw_x = '0;
   logic [COORD_BITS-1:0]     req_raw_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_event_kind;
   logic [SCREEN_BITS-1:0]    rsp_screen_x;
   logic [SCREEN_BITS-1:0]    rsp_screen_y;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [CSR_DATA_BITS-1:0] cal_origin = '0;
   logic [CSR_DATA_BITS-1:0] cal_lower  = LOWER_SPAN_RESET;
   logic [CSR_DATA_BITS-1:0] cal_upper  = UPPER_SPAN_RESET;
   logic [CSR_DATA_BITS-1:0] cal_center = '0;
   logic [CSR_DATA_BITS-1:0] cal_end    = '0;
   logic [ORIENT_BITS-1:0]   cal_orient = '0;

   logic                   pen_down = 1'b0;
   logic [SCREEN_BITS-1:0] pen_x = '0;
   logic [SCREEN_BITS-1:0] pen_y = '0;

   touch_sample_type pending_samples[$];
   touch_event_type  expected_events[$];
   touch_sample_type next_sample;
   touch_event_type  want;
   logic          req_accepted = 1'b0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            mismatches = 0;
   int            samples_taken = 0;
   int            events_checked = 0;
   int            kind_seen[4] = '{0, 0, 0, 0};
   int            cycle_count = 0;

   touch_quadrant_map_and_events_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_valid (req_sample_valid),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic int axis_field(input logic [CSR_DATA_BITS-1:0] r, input logic hi);
      return hi ? int'(r[2*COORD_BITS-1:COORD_BITS]) : int'(r[COORD_BITS-1:0]);
   endfunction

   function automatic int map_axis(input logic [COORD_BITS-1:0] raw, input logic hi);
      int pos, span, ctr, base, q;
      pos  = int'(raw) - axis_field(cal_origin, hi);
      span = axis_field(cal_lower, hi);
      ctr  = axis_field(cal_center, hi);
      base = 0;
      if (pos > span) begin
         pos  = pos - span;
         span = axis_field(cal_upper, hi);
         base = ctr + 1;
      end
      q = (span == 0) ? 0 : (pos * ctr) / span;
      if (q < 0) q = 0;
      if (q > ctr) q = ctr;
      return q + base;
   endfunction

   function automatic logic [SCREEN_BITS-1:0] fit_screen(input int v);
      if (v < 0) return '0;
      if (v > SCREEN_MAX) return '1;
      return v[SCREEN_BITS-1:0];
   endfunction

   function automatic touch_event_type map_touch(input logic present,
                                                 input logic [COORD_BITS-1:0] rx,
                                                 input logic [COORD_BITS-1:0] ry);
      touch_event_type ev;
      int x, y, t;
      ev = '{EV_NONE, '0, '0};
      if (present) begin
         x = map_axis(rx, 1'b0);
         y = map_axis(ry, 1'b1);
         if (cal_orient[ORIENT_HFLIP]) x = axis_field(cal_end, 1'b0) - x;
         if (cal_orient[ORIENT_VFLIP]) y = axis_field(cal_end, 1'b1) - y;
         if (cal_orient[ORIENT_SWAP]) begin
            t = x;
            x = y;
            y = t;
         end
         pen_x = fit_screen(x);
         pen_y = fit_screen(y);
         if (pen_down) begin
            ev.kind = EV_DRAG;
         end else begin
            ev.kind = EV_PUSH;
         end
         pen_down = 1'b1;
         ev.x = pen_x;
         ev.y = pen_y;
      end else if (pen_down) begin
         pen_down = 1'b0;
         ev.kind = EV_RELEASE;
         ev.x = pen_x;
         ev.y = pen_y;
      end
      return ev;
   endfunction

   // driver: hold the payload until its transfer, then advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_sample = pending_samples.pop_front();
            req_valid        <= 1'b1;
            req_sample_valid <= next_sample.present;
            req_raw_x        <= next_sample.raw_x;
            req_raw_y        <= next_sample.raw_y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // monitor: check result transfers, predict on each sample transfer
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("result transfer with nothing expected: kind %0d x %0d y %0d",
                      rsp_event_kind, rsp_screen_x, rsp_screen_y);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               events_checked++;
               kind_seen[want.kind]++;
               if (rsp_event_kind !== want.kind) begin
                  $error("event_kind: expected %0d, got %0d", want.kind, rsp_event_kind);
                  mismatches++;
               end
               if (rsp_screen_x !== want.x) begin
                  $error("screen_x: expected %0d, got %0d", want.x, rsp_screen_x);
                  mismatches++;
               end
               if (rsp_screen_y !== want.y) begin
                  $error("screen_y: expected %0d, got %0d", want.y, rsp_screen_y);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_events.push_back(map_touch(req_sample_valid, req_raw_x, req_raw_y));
            samples_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_events.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_ORIGIN:     cal_origin = data;
         REG_LOWER_SPAN: cal_lower  = data;
         REG_UPPER_SPAN: cal_upper  = data;
         REG_CENTER:     cal_center = data;
         REG_SCREEN_END: cal_end    = data;
         REG_ORIENT:     cal_orient = data[ORIENT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DATA_BITS-1:0] org, lower, upper, ctr, last,
                            input logic [CSR_DATA_BITS-1:0] orient);
      write_csr(REG_ORIGIN, org);
      write_csr(REG_LOWER_SPAN, lower);
      write_csr(REG_UPPER_SPAN, upper);
      write_csr(REG_CENTER, ctr);
      write_csr(REG_SCREEN_END, last);
      write_csr(REG_ORIENT, orient);
   endtask

   task automatic add_sample(input logic present, input logic [COORD_BITS-1:0] x, y);
      pending_samples.push_back('{present, x, y});
   endtask

   task automatic settle();
      while (pending_samples.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] rand_field(input int limit);
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return COORD_BITS'($urandom_range(limit));
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] rand_pair(input int limit);
      return {rand_field(limit), rand_field(limit)};
   endfunction

   // bias towards the lower/upper quadrant boundary and the origin
   function automatic logic [COORD_BITS-1:0] pick_raw(input logic hi);
      logic [COORD_BITS-1:0] org, lspan;
      int sel;
      org   = COORD_BITS'(axis_field(cal_origin, hi));
      lspan = COORD_BITS'(axis_field(cal_lower, hi));
      sel   = $urandom_range(9);
      if (sel < 6) return COORD_BITS'($urandom_range(SCREEN_MAX));
      if (sel < 8) return org + lspan + COORD_BITS'($urandom_range(4)) - COORD_BITS'(2);
      if (sel == 8) return org;
      return $urandom_range(1) ? '1 : '0;
   endfunction

   task automatic queue_strokes(input int count);
      int n, len;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            add_sample(1'($urandom_range(1)), pick_raw(1'b0), pick_raw(1'b1));
            n++;
         end else begin
            len = $urandom_range(1, 8);
            repeat (len) add_sample(1'b1, pick_raw(1'b0), pick_raw(1'b1));
            n = n + len;
            len = $urandom_range(1, 2);
            repeat (len) add_sample(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom));
            n = n + len;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration
      add_sample(1'b1, 12'hFFF, 12'h000);
      add_sample(1'b0, 12'h000, 12'h000);
      settle();

      write_all({12'd200, 12'd100}, {12'd1800, 12'd1900}, {12'd2095, 12'd1800},
                {12'd1500, 12'd2000}, {12'd3000, 12'd4095}, '0);
      write_csr(REG_SPARE_LO, 24'hFFFFFF);
      write_csr(REG_SPARE_HI, 24'h5A5A5A);
      add_sample(1'b0, 12'd77, 12'd88);
      add_sample(1'b1, 12'd0, 12'd0);
      add_sample(1'b1, 12'd4095, 12'd4095);
      add_sample(1'b1, 12'd2000, 12'd2000);
      add_sample(1'b1, 12'd2001, 12'd2001);
      add_sample(1'b0, 12'd0, 12'd0);
      add_sample(1'b0, 12'd4095, 12'd4095);
      settle();

      for (int o = 0; o < 8; o++) begin
         write_csr(REG_ORIENT, {21'($urandom), 3'(o)});
         add_sample(1'b1, COORD_BITS'($urandom), COORD_BITS'($urandom));
         add_sample(1'b0, 12'd0, 12'd0);
         settle();
      end

      // zero span on x, full-scale lower quadrant on y, flips below zero
      write_all({12'd0, 12'd4095}, {12'd4095, 12'd0}, {12'd0, 12'd0},
                {12'd4095, 12'd4095}, '0, 24'd3);
      add_sample(1'b1, 12'd4095, 12'd4095);
      add_sample(1'b1, 12'd0, 12'd1);
      add_sample(1'b0, 12'd0, 12'd0);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 0) begin
            write_all('0, '0, '0, '0, '0, '0);
         end else if (p == 1) begin
            write_all('1, '1, '1, '1, '1, '1);
         end else begin
            write_all(rand_pair(800), rand_pair(2500), rand_pair(2500), rand_pair(4095),
                      rand_pair(4095), CSR_DATA_BITS'($urandom));
         end
         send_idle_pct  = SEND_IDLE[p % 4];
         recv_stall_pct = RECV_STALL[p % 4];
         queue_strokes(PHASE_SAMPLES);
         settle();
      end

      if (expected_events.size() != 0) begin
         $error("%0d expected results never arrived", expected_events.size());
         mismatches++;
      end
      $display("Checked %0d results from %0d samples over %0d calibration phases.",
               events_checked, samples_taken, NUM_PHASES);
      $display("Events seen: none %0d, push %0d, drag %0d, release %0d.",
               kind_seen[EV_NONE], kind_seen[EV_PUSH], kind_seen[EV_DRAG],
               kind_seen[EV_RELEASE]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
